@@ rtl/bfsa_pkg.sv @@
package bfsa_pkg;

	localparam int ITER = 28;
	localparam int DW = 48;
	localparam int ZW = 32;
	localparam int BW = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [ZW-1:0] PI_Q28 = 32'sd843314857;
	localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
	localparam logic signed [ZW-1:0] TWO_PI_Q28 = 32'sd1686629713;
	localparam logic signed [BW-1:0] INVK_Q28 = 32'sd163008219;
	localparam logic signed [17:0] INVK_Q16 = 18'sd39797;
	localparam logic signed [16:0] POLAR_MAX = 17'sd12868;
	localparam logic signed [16:0] AZ_MIN = -17'sd6434;
	localparam logic signed [16:0] AZ_MAX = 17'sd19302;

	typedef enum logic [2:0] {
		REG_BODY_X,
		REG_BODY_Y,
		REG_BODY_Z,
		REG_TILT,
		REG_NODE,
		REG_SPIN
	} reg_idx_t;

	typedef logic signed [BW-1:0] bq_t;

	typedef struct packed {
		bq_t b00, b01, b02;
		bq_t b10, b11, b12;
		bq_t b20, b21, b22;
	} basis_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} body_t;

	typedef struct packed {
		logic zero;
		logic signed [DW-1:0] xc;
		logic signed [DW-1:0] yc;
		logic signed [DW-1:0] zc;
	} item_t;

	function automatic logic [28:0] atan_q28(input logic [4:0] i);
		logic [28:0] r;
		case (i)
			5'd0: r = 29'd210828714;
			5'd1: r = 29'd124459457;
			5'd2: r = 29'd65760959;
			5'd3: r = 29'd33381290;
			5'd4: r = 29'd16755422;
			5'd5: r = 29'd8385879;
			5'd6: r = 29'd4193963;
			5'd7: r = 29'd2097109;
			5'd8: r = 29'd1048571;
			5'd9: r = 29'd524287;
			5'd10: r = 29'd262144;
			5'd11: r = 29'd131072;
			5'd12: r = 29'd65536;
			5'd13: r = 29'd32768;
			5'd14: r = 29'd16384;
			5'd15: r = 29'd8192;
			5'd16: r = 29'd4096;
			5'd17: r = 29'd2048;
			5'd18: r = 29'd1024;
			5'd19: r = 29'd512;
			5'd20: r = 29'd256;
			5'd21: r = 29'd128;
			5'd22: r = 29'd64;
			5'd23: r = 29'd32;
			5'd24: r = 29'd16;
			5'd25: r = 29'd8;
			5'd26: r = 29'd4;
			5'd27: r = 29'd2;
			default: r = 29'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/bfsa_cfg.sv @@
module bfsa_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	output bfsa_pkg::body_t        body,
	output bfsa_pkg::basis_t       basis,
	output logic                   basis_ready
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_ROT,
		S_MUL,
		S_FIN,
		S_IDLE
	} state_t;

	localparam int BW = bfsa_pkg::BW;

	state_t state_q;
	logic [1:0] k_q;
	logic [4:0] it_q;
	logic [3:0] step_q;
	bfsa_pkg::body_t body_q;
	logic signed [15:0] tilt_q, node_q, spin_q;

	logic signed [BW-1:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic neg_q;
	logic signed [BW-1:0] st_q, ct_q, sp_q, cp_q, ss_q, cs_q;
	logic signed [BW-1:0] prod_q [14];
	bfsa_pkg::basis_t basis_q;

	logic wr;
	logic angle_wr;
	logic signed [15:0] ang;
	logic signed [33:0] zr;
	logic zneg;
	logic signed [BW-1:0] nx, ny, sv, cv;
	logic signed [33:0] nz;
	logic signed [33:0] at;
	logic signed [BW-1:0] opa, opb, mq;
	logic signed [63:0] prod;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;
	assign angle_wr = wr && (cfg_index == bfsa_pkg::REG_TILT ||
		cfg_index == bfsa_pkg::REG_NODE || cfg_index == bfsa_pkg::REG_SPIN);
	assign body = body_q;
	assign basis = basis_q;
	assign basis_ready = (state_q == S_IDLE);

	always_comb begin
		case (k_q)
			2'd0: ang = tilt_q;
			2'd1: ang = node_q;
			default: ang = spin_q;
		endcase
		zr = {{2{ang[15]}}, ang, 16'b0};
		if (zr > 34'(bfsa_pkg::PI_Q28)) begin
			zr = zr - 34'(bfsa_pkg::TWO_PI_Q28);
		end
		if (zr < -34'(bfsa_pkg::PI_Q28)) begin
			zr = zr + 34'(bfsa_pkg::TWO_PI_Q28);
		end
		zneg = 1'b0;
		if (zr > 34'(bfsa_pkg::HALF_PI_Q28)) begin
			zr = zr - 34'(bfsa_pkg::PI_Q28);
			zneg = 1'b1;
		end else if (zr < -34'(bfsa_pkg::HALF_PI_Q28)) begin
			zr = zr + 34'(bfsa_pkg::PI_Q28);
			zneg = 1'b1;
		end
	end

	always_comb begin
		at = $signed({5'b0, bfsa_pkg::atan_q28(it_q)});
		if (z_q >= 0) begin
			nx = x_q - (y_q >>> it_q);
			ny = y_q + (x_q >>> it_q);
			nz = z_q - at;
		end else begin
			nx = x_q + (y_q >>> it_q);
			ny = y_q - (x_q >>> it_q);
			nz = z_q + at;
		end
		cv = neg_q ? -nx : nx;
		sv = neg_q ? -ny : ny;
	end

	always_comb begin
		case (step_q)
			4'd0: begin opa = ct_q; opb = sp_q; end
			4'd1: begin opa = ct_q; opb = cp_q; end
			4'd2: begin opa = cs_q; opb = cp_q; end
			4'd3: begin opa = prod_q[0]; opb = ss_q; end
			4'd4: begin opa = cs_q; opb = sp_q; end
			4'd5: begin opa = prod_q[1]; opb = ss_q; end
			4'd6: begin opa = ss_q; opb = st_q; end
			4'd7: begin opa = ss_q; opb = cp_q; end
			4'd8: begin opa = prod_q[0]; opb = cs_q; end
			4'd9: begin opa = ss_q; opb = sp_q; end
			4'd10: begin opa = prod_q[1]; opb = cs_q; end
			4'd11: begin opa = cs_q; opb = st_q; end
			4'd12: begin opa = st_q; opb = sp_q; end
			4'd13: begin opa = st_q; opb = cp_q; end
			default: begin opa = '0; opb = '0; end
		endcase
		prod = 64'(opa) * 64'(opb) + 64'sd134217728;
		mq = BW'(prod >>> 28);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			k_q <= '0;
			it_q <= '0;
			step_q <= '0;
			body_q <= '0;
			tilt_q <= '0;
			node_q <= '0;
			spin_q <= '0;
		end else begin
			if (wr) begin
				case (bfsa_pkg::reg_idx_t'(cfg_index))
					bfsa_pkg::REG_BODY_X: body_q.x <= cfg_data;
					bfsa_pkg::REG_BODY_Y: body_q.y <= cfg_data;
					bfsa_pkg::REG_BODY_Z: body_q.z <= cfg_data;
					bfsa_pkg::REG_TILT: tilt_q <= cfg_data[15:0];
					bfsa_pkg::REG_NODE: node_q <= cfg_data[15:0];
					bfsa_pkg::REG_SPIN: spin_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (angle_wr) begin
				state_q <= S_LOAD;
				k_q <= '0;
			end else begin
				case (state_q)
					S_LOAD: begin
						it_q <= '0;
						state_q <= S_ROT;
					end
					S_ROT: begin
						if (it_q == 5'(bfsa_pkg::ITER - 1)) begin
							if (k_q == 2'd2) begin
								step_q <= '0;
								state_q <= S_MUL;
							end else begin
								k_q <= k_q + 2'd1;
								state_q <= S_LOAD;
							end
						end else begin
							it_q <= it_q + 5'd1;
						end
					end
					S_MUL: begin
						if (step_q == 4'd13) begin
							state_q <= S_FIN;
						end else begin
							step_q <= step_q + 4'd1;
						end
					end
					S_FIN: state_q <= S_IDLE;
					S_IDLE: ;
					default: state_q <= S_LOAD;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				x_q <= bfsa_pkg::INVK_Q28;
				y_q <= '0;
				z_q <= zr;
				neg_q <= zneg;
			end
			S_ROT: begin
				x_q <= nx;
				y_q <= ny;
				z_q <= nz;
				if (it_q == 5'(bfsa_pkg::ITER - 1)) begin
					case (k_q)
						2'd0: begin st_q <= sv; ct_q <= cv; end
						2'd1: begin sp_q <= sv; cp_q <= cv; end
						default: begin ss_q <= sv; cs_q <= cv; end
					endcase
				end
			end
			S_MUL: prod_q[step_q] <= mq;
			S_FIN: begin
				basis_q.b00 <= prod_q[2] - prod_q[3];
				basis_q.b01 <= prod_q[4] + prod_q[5];
				basis_q.b02 <= prod_q[6];
				basis_q.b10 <= -prod_q[7] - prod_q[8];
				basis_q.b11 <= prod_q[10] - prod_q[9];
				basis_q.b12 <= prod_q[11];
				basis_q.b20 <= prod_q[12];
				basis_q.b21 <= -prod_q[13];
				basis_q.b22 <= ct_q;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/bfsa_front.sv @@
module bfsa_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [95:0]           in_data,
	input  logic                  basis_ready,
	input  bfsa_pkg::body_t       body,
	input  bfsa_pkg::basis_t      basis,
	output logic                  push,
	output bfsa_pkg::item_t       push_item,
	input  logic                  q_full
);

	localparam int BW = bfsa_pkg::BW;
	localparam int DW = bfsa_pkg::DW;

	logic adv;
	logic v1_s, v2_s, v3_s, v4_s;
	logic z1_s, z2_s, z3_s, z4_s;
	logic signed [32:0] d_s1 [3];
	logic signed [BW+16:0] pl_s2 [3][3];
	logic signed [BW+16:0] ph_s2 [3][3];
	logic signed [63:0] p_s3 [3][3];
	logic signed [DW-1:0] c_s4 [3];
	logic signed [BW-1:0] bm [3][3];
	logic signed [31:0] pt [3];
	logic signed [31:0] bc [3];
	logic signed [65:0] sum [3];

	assign adv = !v4_s || !q_full;
	assign in_ready = basis_ready && adv;
	assign push = v4_s && !q_full;

	assign pt[0] = in_data[31:0];
	assign pt[1] = in_data[63:32];
	assign pt[2] = in_data[95:64];
	assign bc[0] = body.x;
	assign bc[1] = body.y;
	assign bc[2] = body.z;

	assign bm[0][0] = basis.b00;
	assign bm[0][1] = basis.b01;
	assign bm[0][2] = basis.b02;
	assign bm[1][0] = basis.b10;
	assign bm[1][1] = basis.b11;
	assign bm[1][2] = basis.b12;
	assign bm[2][0] = basis.b20;
	assign bm[2][1] = basis.b21;
	assign bm[2][2] = basis.b22;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = 66'(p_s3[r][0]) + 66'(p_s3[r][1]) + 66'(p_s3[r][2]) + 66'sd524288;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s <= 1'b0;
			v2_s <= 1'b0;
			v3_s <= 1'b0;
			v4_s <= 1'b0;
		end else if (adv) begin
			v1_s <= in_valid && in_ready;
			v2_s <= v1_s;
			v3_s <= v2_s;
			v4_s <= v3_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				d_s1[j] <= 33'(pt[j]) - 33'(bc[j]);
			end
			z1_s <= (pt[0] == bc[0]) && (pt[1] == bc[1]) && (pt[2] == bc[2]);
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					pl_s2[r][j] <= $signed({1'b0, d_s1[j][15:0]}) * bm[r][j];
					ph_s2[r][j] <= $signed(d_s1[j][32:16]) * bm[r][j];
					p_s3[r][j] <= (64'(ph_s2[r][j]) <<< 16) + 64'(pl_s2[r][j]);
				end
				c_s4[r] <= DW'(sum[r] >>> 20);
			end
			z2_s <= z1_s;
			z3_s <= z2_s;
			z4_s <= z3_s;
		end
	end

	assign push_item.zero = z4_s;
	assign push_item.xc = c_s4[0];
	assign push_item.yc = c_s4[1];
	assign push_item.zc = c_s4[2];

endmodule

@@ rtl/bfsa_queue.sv @@
module bfsa_queue #(
	parameter int DEPTH = bfsa_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bfsa_pkg::item_t  push_item,
	output logic             full,
	input  logic             pop,
	output bfsa_pkg::item_t  head,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bfsa_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

endmodule

@@ rtl/bfsa_back.sv @@
module bfsa_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bfsa_pkg::item_t  head,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [13:0]      polar_out,
	output logic [15:0]      azimuth_out,
	output logic             zero_offset
);

	localparam int DW = bfsa_pkg::DW;
	localparam int ZW = bfsa_pkg::ZW;
	localparam int ITER = bfsa_pkg::ITER;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
	} cv_t;

	typedef struct packed {
		logic zero;
		logic xneg;
		logic signed [DW-1:0] ax;
		logic signed [DW-1:0] yc;
		logic signed [DW-1:0] zc;
		logic signed [ZW-1:0] az;
	} car_t;

	function automatic cv_t vec_step(input cv_t a, input int sh);
		cv_t r;
		logic signed [ZW-1:0] at;
		at = $signed(ZW'(bfsa_pkg::atan_q28(5'(sh))));
		if (a.y >= 0) begin
			r.x = a.x + (a.y >>> sh);
			r.y = a.y - (a.x >>> sh);
			r.z = a.z + at;
		end else begin
			r.x = a.x - (a.y >>> sh);
			r.y = a.y + (a.x >>> sh);
			r.z = a.z - at;
		end
		return r;
	endfunction

	function automatic logic signed [DW-1:0] comp_gain(input logic signed [DW-1:0] m);
		logic signed [DW+17:0] p;
		p = m * bfsa_pkg::INVK_Q16;
		p = p + (DW+18)'(32768);
		return DW'(p >>> 16);
	endfunction

	function automatic logic signed [16:0] to_q12(input logic signed [ZW-1:0] a,
		input logic signed [16:0] lo, input logic signed [16:0] hi);
		logic signed [ZW:0] t;
		logic signed [16:0] r;
		t = (ZW+1)'(a) + (ZW+1)'(32768);
		r = 17'(t >>> 16);
		if (r < lo) begin
			r = lo;
		end
		if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

	logic adv;
	logic [ITER:0] val1_s, val2_s;
	cv_t v1_s [ITER+1];
	car_t c1_s [ITER+1];
	cv_t v2_s [ITER+1];
	car_t c2_s [ITER+1];
	logic g_val_s, n_val_s, f_val_s;
	logic signed [DW-1:0] h_s;
	car_t g_s, n_c_s;
	logic signed [DW-1:0] n_s;
	logic signed [ZW-1:0] pol_n_s;
	logic signed [ZW-1:0] pol_f_s, az_f_s;
	logic zero_f_s;
	logic out_valid_q;
	logic [13:0] polar_q;
	logic [15:0] azimuth_q;
	logic zero_q;

	car_t g_in;
	logic signed [DW-1:0] thr;
	logic signed [ZW-1:0] az_sel;
	logic signed [16:0] pol_r, az_r;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !empty;
	assign out_valid = out_valid_q;
	assign polar_out = polar_q;
	assign azimuth_out = azimuth_q;
	assign zero_offset = zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val1_s <= '0;
			val2_s <= '0;
			g_val_s <= 1'b0;
			n_val_s <= 1'b0;
			f_val_s <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			val1_s <= {val1_s[ITER-1:0], pop};
			g_val_s <= val1_s[ITER];
			val2_s <= {val2_s[ITER-1:0], g_val_s};
			n_val_s <= val2_s[ITER];
			f_val_s <= n_val_s;
			out_valid_q <= f_val_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v1_s[0].x <= (head.xc < 0) ? -head.xc : head.xc;
			v1_s[0].y <= (head.xc < 0) ? -head.yc : head.yc;
			v1_s[0].z <= '0;
			c1_s[0].zero <= head.zero;
			c1_s[0].xneg <= head.xc < 0;
			c1_s[0].ax <= (head.xc < 0) ? -head.xc : head.xc;
			c1_s[0].yc <= head.yc;
			c1_s[0].zc <= head.zc;
			c1_s[0].az <= '0;

			h_s <= comp_gain(v1_s[ITER].x);
			g_s <= g_in;

			v2_s[0].x <= (g_s.zc >= 0) ? g_s.zc : h_s;
			v2_s[0].y <= (g_s.zc >= 0) ? h_s : -g_s.zc;
			v2_s[0].z <= '0;
			c2_s[0] <= g_s;

			n_s <= comp_gain(v2_s[ITER].x);
			pol_n_s <= (c2_s[ITER].zc < 0) ? v2_s[ITER].z + bfsa_pkg::HALF_PI_Q28
				: v2_s[ITER].z;
			n_c_s <= c2_s[ITER];

			pol_f_s <= pol_n_s;
			az_f_s <= az_sel;
			zero_f_s <= n_c_s.zero;

			zero_q <= zero_f_s;
			polar_q <= zero_f_s ? '0 : pol_r[13:0];
			azimuth_q <= zero_f_s ? '0 : az_r[15:0];
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				v1_s[i+1] <= vec_step(v1_s[i], i);
				c1_s[i+1] <= c1_s[i];
				v2_s[i+1] <= vec_step(v2_s[i], i);
				c2_s[i+1] <= c2_s[i];
			end
		end
	end

	always_comb begin
		g_in = c1_s[ITER];
		g_in.az = v1_s[ITER].z;
		thr = (n_s > 0) ? (n_s >>> 30) : '0;
		if (n_c_s.ax <= thr) begin
			if (n_c_s.yc > thr) begin
				az_sel = bfsa_pkg::HALF_PI_Q28;
			end else if (n_c_s.yc < -thr) begin
				az_sel = -bfsa_pkg::HALF_PI_Q28;
			end else begin
				az_sel = '0;
			end
		end else if (n_c_s.xneg) begin
			az_sel = n_c_s.az + bfsa_pkg::PI_Q28;
		end else begin
			az_sel = n_c_s.az;
		end
		pol_r = to_q12(pol_f_s, 17'sd0, bfsa_pkg::POLAR_MAX);
		az_r = to_q12(az_f_s, bfsa_pkg::AZ_MIN, bfsa_pkg::AZ_MAX);
	end

endmodule

@@ rtl/body_frame_spherical_angles_unit.sv @@
// Direction of a query point seen from a body, as polar and azimuth angles in the
// body's own frame. The body centre and its z-x-z Euler angles are written over the
// cfg channel; registers 0 to 2 hold the centre, 3 to 5 the tilt, node and spin angles.
// Points arrive on the s_ channel and one result leaves on the m_ channel per point,
// in order. With no stall, one point is taken every cycle.
// The front stages form the offset and project it onto the body axes; a short queue
// then feeds two 28-stage vectoring pipelines that give the azimuth and the polar angle.
// After reset, and after each write of an angle register, a sequencer rebuilds the body
// axes with one shared rotation unit and one multiplier; s_tready stays low until it is
// done. When the receiver holds m_tready low the back pipeline stops, the queue
// fills, and then s_tready falls; nothing is dropped. The user must ensure configuration is
// written only while no point is in flight; the block itself does not enforce it.
module body_frame_spherical_angles_unit #(
	parameter int QDEPTH = bfsa_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // point_x, point_y, point_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // polar_out, azimuth_out, two zero bits
	output logic        m_tuser,  // zero_offset
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	bfsa_pkg::body_t body;
	bfsa_pkg::basis_t basis;
	logic basis_ready;
	logic push, q_full, pop, q_empty;
	bfsa_pkg::item_t push_item, head;
	logic [13:0] polar_out;
	logic [15:0] azimuth_out;

	bfsa_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.body(body),
		.basis(basis),
		.basis_ready(basis_ready)
	);

	bfsa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_data(s_tdata),
		.basis_ready(basis_ready),
		.body(body),
		.basis(basis),
		.push(push),
		.push_item(push_item),
		.q_full(q_full)
	);

	bfsa_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop(pop),
		.head(head),
		.empty(q_empty)
	);

	bfsa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(q_empty),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.polar_out(polar_out),
		.azimuth_out(azimuth_out),
		.zero_offset(m_tuser)
	);

	assign m_tdata = {2'b00, azimuth_out, polar_out};

endmodule

@@ tb/body_frame_spherical_angles_unit_tb.sv @@
module body_frame_spherical_angles_unit_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int ITEMS_PER_PHASE = 142;

	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	localparam logic signed [31:0] C_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] C_MIN = 32'sh80000000;

	localparam longint RND_Q28 = 64'sd134217728;
	localparam longint RND_Q20 = 64'sd524288;
	localparam longint RND_Q16 = 64'sd32768;
	localparam longint ANG_PI = 64'sd843314857;
	localparam longint ANG_HALF_PI = 64'sd421657428;
	localparam longint ANG_TWO_PI = 64'sd1686629713;
	localparam longint GAIN_INV_Q28 = 64'sd163008219;
	localparam longint GAIN_INV_Q16 = 64'sd39797;
	localparam longint ARCTAN_STEP [28] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
		2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
	};

	typedef struct {
		logic [13:0] polar;
		logic signed [15:0] azimuth;
		logic zero;
	} angles_t;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		bit typed;
		angles_t known;
	} point_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [95:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	logic signed [31:0] body_x_r, body_y_r, body_z_r;
	logic signed [15:0] tilt_r, node_r, spin_r;

	angles_t angles_q[$];
	int errors;
	int quiet_cycles;
	bit send_burst, recv_burst;

	body_frame_spherical_angles_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint mul_q28(longint a, longint b);
		return (a * b + RND_Q28) >>> 28;
	endfunction

	function automatic void rotate_sincos(input longint ang, output longint s, output longint c);
		longint z, x, y, nx, ny;
		bit flip;
		z = ang * 65536;
		x = GAIN_INV_Q28;
		y = 0;
		flip = 1'b0;
		if (z > ANG_PI) z -= ANG_TWO_PI;
		if (z < -ANG_PI) z += ANG_TWO_PI;
		if (z > ANG_HALF_PI) begin
			z -= ANG_PI;
			flip = 1'b1;
		end else if (z < -ANG_HALF_PI) begin
			z += ANG_PI;
			flip = 1'b1;
		end
		for (int i = 0; i < 28; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ARCTAN_STEP[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ARCTAN_STEP[i];
			end
			x = nx;
			y = ny;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic void vector_angle(input longint xi, input longint yi,
			output longint mag, output longint ang);
		longint x, y, z, nx, ny;
		x = xi;
		y = yi;
		z = 0;
		for (int i = 0; i < 28; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ARCTAN_STEP[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ARCTAN_STEP[i];
			end
			x = nx;
			y = ny;
		end
		mag = x;
		ang = z;
	endfunction

	function automatic longint unscale_gain(longint m);
		return (m * GAIN_INV_Q16 + RND_Q16) >>> 16;
	endfunction

	function automatic longint round_angle(longint a, longint lo, longint hi);
		longint r;
		r = (a + RND_Q16) >>> 16;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

	function automatic longint dot_axis(longint d0, longint d1, longint d2,
			longint b0, longint b1, longint b2);
		return (d0 * b0 + d1 * b1 + d2 * b2 + RND_Q20) >>> 20;
	endfunction

	function automatic angles_t predict_angles(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		angles_t r;
		longint d0, d1, d2, st, ct, sp, cp, ss, cs, ts, tc;
		longint xc, yc, zc, hraw, az, h, pol, m2, n, thr, ax;
		d0 = longint'(px) - longint'(body_x_r);
		d1 = longint'(py) - longint'(body_y_r);
		d2 = longint'(pz) - longint'(body_z_r);
		r.polar = '0;
		r.azimuth = '0;
		r.zero = 1'b1;
		if (d0 == 0 && d1 == 0 && d2 == 0) return r;
		rotate_sincos(longint'(tilt_r), st, ct);
		rotate_sincos(longint'(node_r), sp, cp);
		rotate_sincos(longint'(spin_r), ss, cs);
		ts = mul_q28(ct, sp);
		tc = mul_q28(ct, cp);
		xc = dot_axis(d0, d1, d2, mul_q28(cs, cp) - mul_q28(ts, ss),
			mul_q28(cs, sp) + mul_q28(tc, ss), mul_q28(ss, st));
		yc = dot_axis(d0, d1, d2, -mul_q28(ss, cp) - mul_q28(ts, cs),
			-mul_q28(ss, sp) + mul_q28(tc, cs), mul_q28(cs, st));
		zc = dot_axis(d0, d1, d2, mul_q28(st, sp), -mul_q28(st, cp), ct);
		if (xc < 0) vector_angle(-xc, -yc, hraw, az);
		else vector_angle(xc, yc, hraw, az);
		h = unscale_gain(hraw);
		if (zc >= 0) begin
			vector_angle(zc, h, m2, pol);
		end else begin
			vector_angle(h, -zc, m2, pol);
			pol += ANG_HALF_PI;
		end
		n = unscale_gain(m2);
		thr = (n > 0) ? (n >>> 30) : 0;
		ax = (xc < 0) ? -xc : xc;
		if (ax <= thr) begin
			if (yc > thr) az = ANG_HALF_PI;
			else if (yc < -thr) az = -ANG_HALF_PI;
			else az = 0;
		end else if (xc < 0) begin
			az += ANG_PI;
		end
		r.polar = 14'(round_angle(pol, 0, 12868));
		r.azimuth = 16'(round_angle(az, -6434, 19302));
		r.zero = 1'b0;
		return r;
	endfunction

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 17);
	endfunction

	task automatic wait_idle();
		while (angles_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			bfsa_pkg::REG_BODY_X: body_x_r = value;
			bfsa_pkg::REG_BODY_Y: body_y_r = value;
			bfsa_pkg::REG_BODY_Z: body_z_r = value;
			bfsa_pkg::REG_TILT: tilt_r = value[15:0];
			bfsa_pkg::REG_NODE: node_r = value[15:0];
			bfsa_pkg::REG_SPIN: spin_r = value[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
			logic [15:0] tilt, logic [15:0] node, logic [15:0] spin);
		wait_idle();
		write_reg(bfsa_pkg::REG_BODY_X, bx);
		write_reg(bfsa_pkg::REG_BODY_Y, by);
		write_reg(bfsa_pkg::REG_BODY_Z, bz);
		write_reg(bfsa_pkg::REG_TILT, {16'h0, tilt});
		write_reg(bfsa_pkg::REG_NODE, {16'h0, node});
		write_reg(bfsa_pkg::REG_SPIN, {16'h0, spin});
	endtask

	task automatic send_point(point_row_t row);
		int gap;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {row.pz, row.py, row.px};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		angles_q.push_back(row.typed ? row.known : predict_angles(row.px, row.py, row.pz));
	endtask

	function automatic point_row_t random_point();
		point_row_t row;
		int mode;
		mode = $urandom_range(0, 9);
		row.typed = 1'b0;
		row.px = $urandom;
		row.py = $urandom;
		row.pz = $urandom;
		case (mode)
			4, 5, 6: begin
				row.px = body_x_r + $signed(12'($urandom));
				row.py = body_y_r + $signed(12'($urandom));
				row.pz = body_z_r + $signed(12'($urandom));
			end
			7: begin
				row.px = body_x_r + $signed(2'($urandom));
				row.py = body_y_r + $signed(24'($urandom));
				row.pz = body_z_r + $signed(20'($urandom));
			end
			8: begin
				row.px = body_x_r;
				row.py = body_y_r;
				row.pz = body_z_r;
			end
			9: begin
				row.px = body_x_r;
				row.py = body_y_r;
			end
			default: ;
		endcase
		return row;
	endfunction

	task automatic run_random(int count, bit hold_once);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
			if (hold_once && i == count / 2) begin
				s_tvalid <= 1'b0;
				while (angles_q.size() != 0) @(posedge clk);
			end
			send_point(random_point());
		end
		s_tvalid <= 1'b0;
	endtask

	always @(posedge clk) begin
		angles_t want;
		if (m_tvalid && m_tready) begin
			if (angles_q.size() == 0) begin
				$display("%0t: unexpected result polar=%0d azimuth=%0d zero=%0b", $time,
					m_tdata[13:0], $signed(m_tdata[29:14]), m_tuser);
				errors++;
			end else begin
				want = angles_q.pop_front();
				if (m_tdata[13:0] !== want.polar) begin
					$display("%0t: polar expected %0d actual %0d", $time, want.polar,
						m_tdata[13:0]);
					errors++;
				end
				if (m_tdata[29:14] !== want.azimuth) begin
					$display("%0t: azimuth expected %0d actual %0d", $time, want.azimuth,
						$signed(m_tdata[29:14]));
					errors++;
				end
				if (m_tuser !== want.zero) begin
					$display("%0t: zero_offset expected %0b actual %0b", $time, want.zero,
						m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("body_frame_spherical_angles_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
			gap = draw_gap(recv_burst);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		point_row_t rows[$];
		point_row_t row;
		send_burst = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = bfsa_pkg::REG_BODY_X;
		cfg_data = '0;
		body_x_r = '0;
		body_y_r = '0;
		body_z_r = '0;
		tilt_r = '0;
		node_r = '0;
		spin_r = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers put the body at the origin with no rotation.
		rows = '{
			'{0, 0, 0, 1, '{0, 0, 1}},
			'{1, 0, 0, 0, '{0, 0, 0}},
			'{-1, 0, 0, 0, '{0, 0, 0}},
			'{0, 1, 0, 0, '{0, 0, 0}},
			'{0, -1, 0, 0, '{0, 0, 0}},
			'{0, 0, 1, 0, '{0, 0, 0}},
			'{0, 0, -1, 0, '{0, 0, 0}},
			'{C_MAX, C_MAX, C_MAX, 0, '{0, 0, 0}},
			'{C_MIN, C_MIN, C_MIN, 0, '{0, 0, 0}},
			'{C_MAX, C_MIN, 0, 0, '{0, 0, 0}},
			'{C_MIN, 0, C_MAX, 0, '{0, 0, 0}},
			'{1, 32'sh01000000, 0, 0, '{0, 0, 0}},
			'{1, -32'sh01000000, 0, 0, '{0, 0, 0}},
			'{-1, 32'sh40000000, 5, 0, '{0, 0, 0}},
			'{-1, 1, 32'sh40000000, 0, '{0, 0, 0}},
			'{0, 0, C_MAX, 0, '{0, 0, 0}},
			'{0, 0, C_MIN, 0, '{0, 0, 0}},
			'{-1, -1, -1, 0, '{0, 0, 0}},
			'{-32'sh00100000, 32'sh00100000, 0, 0, '{0, 0, 0}}
		};
		foreach (rows[i]) send_point(rows[i]);
		s_tvalid <= 1'b0;

		configure(C_MAX, C_MIN, 32'h0, 16'h7FFF, 16'h8000, 16'h0000);
		cfg_valid <= 1'b0;
		row = '{C_MAX, C_MIN, 0, 1, '{0, 0, 1}};
		send_point(row);
		run_random(ITEMS_PER_PHASE, 1'b0);

		configure($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
			16'($urandom));
		cfg_valid <= 1'b0;
		run_random(ITEMS_PER_PHASE, 1'b1);

		configure(C_MIN, C_MAX, C_MIN, 16'h8000, 16'h7FFF, 16'h8000);
		cfg_valid <= 1'b0;
		run_random(ITEMS_PER_PHASE, 1'b0);

		configure(32'h0, 32'h0, 32'h0, 16'd6434, 16'd12868, -16'sd6434);
		cfg_valid <= 1'b0;
		run_random(ITEMS_PER_PHASE, 1'b0);

		configure($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
			16'($urandom));
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		cfg_valid <= 1'b0;
		run_random(ITEMS_PER_PHASE, 1'b0);

		configure($urandom, $urandom, $urandom, 16'($urandom_range(0, 1600)),
			16'($urandom_range(0, 1600)), 16'($urandom_range(0, 1600)));
		cfg_valid <= 1'b0;
		run_random(ITEMS_PER_PHASE, 1'b0);

		wait_idle();
		if (errors == 0) begin
			$display("body_frame_spherical_angles_unit: match");
		end else begin
			$display("body_frame_spherical_angles_unit: mismatch");
		end
		$finish;
	end

endmodule
